/* design/assert_macros.svh */
// Assertion macros for the downscaler modules (included by aad_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define AAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define AAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/aad_pkg.sv */
`timescale 1ns / 1ps
package aad_pkg;

  localparam int TARGET_EDGE = 256;
  localparam int MAX_EDGE    = 2048;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

  localparam int EDGE_W  = 12;
  localparam int POS_W   = 11;
  localparam int DST_W   = 9;
  localparam int COORD_W = 8;
  localparam int PIX_W   = 8;
  localparam int NCH     = 4;
  localparam int WGT_W   = 9;
  localparam int PROD_W  = 17;
  localparam int AREA_W  = 23;
  localparam int ACC_W   = 30;
  localparam int ACC_AW  = 9;
  localparam int ACC_DEPTH = 512;
  localparam int NUM_W   = 32;
  localparam int QUO_W   = 9;
  localparam int QUO_STEPS = 9;
  localparam int SZ_W    = 21;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [PIX_W-1:0]   red_out;
    logic [PIX_W-1:0]   green_out;
    logic [PIX_W-1:0]   blue_out;
    logic [PIX_W-1:0]   alpha_out;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               frame_last;
  } out_pix_t;

  typedef struct packed {
    in_pix_t            px;
    logic [COORD_W-1:0] xs0;
    logic [COORD_W-1:0] ys0;
    logic               two_col;
    logic               two_row;
    logic [WGT_W-1:0]   wx0;
    logic [WGT_W-1:0]   wx1;
    logic [WGT_W-1:0]   wy0;
    logic [WGT_W-1:0]   wy1;
    logic               emit;
    logic               last;
  } op_t;

  typedef struct packed {
    logic              restart;
    logic [AREA_W-1:0] area;
  } ctl_t;

endpackage

/* design/area_average_downscaler_top.sv */
`timescale 1ns / 1ps
// Area-averaging RGBA downscaler. One source pixel is taken per request in raster order and
// at most one averaged output pixel leaves per request. Each request passes through the
// accumulator engine as one fetch step plus a read and a write step on the single-port
// accumulator memory for each of the one to four output pixels it touches, and a request
// that completes an output pixel adds the 9-step divider and the output load; the
// accumulator memory port and the divider set the sustained rate. After reset and after
// each write to the width or height register the accumulator memory is cleared (all 512
// entries) with no pixel accepted, and after such a write the output size is recomputed.
module area_average_downscaler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  aad_pkg::in_pix_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output aad_pkg::out_pix_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aad_pkg::CFG_W-1:0]     cfg_data_i
);

  aad_pkg::op_t  push_data, head_data;
  aad_pkg::ctl_t ctl;
  logic          push, pop, q_full, q_empty, clr_busy;

  aad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clr_busy_i  (clr_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_data),
    .ctl_o       (ctl)
  );

  aad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (ctl.restart),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  aad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .q_empty_i   (q_empty),
    .q_data_i    (head_data),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/aad_front.sv */
`timescale 1ns / 1ps
module aad_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  aad_pkg::in_pix_t               in_data_i,
  input  logic                           cfg_we_i,
  input  logic [aad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [aad_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           clr_busy_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output aad_pkg::op_t                   op_o,
  output aad_pkg::ctl_t                  ctl_o
);

  logic [aad_pkg::CFG_W-1:0]   reg_w_q, reg_h_q;
  logic [aad_pkg::EDGE_W-1:0]  w_eff, h_eff, m_eff;
  logic                        sz_load_q;
  logic [3:0]                  sz_cnt_q;
  logic [aad_pkg::SZ_W-1:0]    remw_q, remh_q, dsh_q, remw_d, remh_d;
  logic [aad_pkg::QUO_W-1:0]   qw_q, qh_q, qw_d, qh_d;
  logic                        gew, geh, ident;
  logic [aad_pkg::DST_W-1:0]   dw_q, dh_q;
  logic [aad_pkg::AREA_W-1:0]  area_q;
  logic [2*aad_pkg::EDGE_W-1:0] area_full;
  logic [aad_pkg::POS_W-1:0]   sx_q, sy_q, crem_q, rrem_q;
  logic [aad_pkg::COORD_W-1:0] xs_q, ys_q;
  logic [aad_pkg::EDGE_W-1:0]  cend, rend, wx0_f, wx1_f, wy0_f, wy1_f, sx_inc, sy_inc;
  logic                        two_col, two_row, col_done, row_done, cfg_hit, accept;

  function automatic logic [aad_pkg::EDGE_W-1:0] eff(input logic [aad_pkg::CFG_W-1:0] v);
    logic [aad_pkg::EDGE_W-1:0] r;
    r = v;
    if (v == '0) r = aad_pkg::EDGE_W'(1);
    else if (v > aad_pkg::CFG_W'(aad_pkg::MAX_EDGE)) r = aad_pkg::EDGE_W'(aad_pkg::MAX_EDGE);
    return r;
  endfunction

  assign w_eff = eff(reg_w_q);
  assign h_eff = eff(reg_h_q);
  assign m_eff = (w_eff > h_eff) ? w_eff : h_eff;
  assign ident = (w_eff <= aad_pkg::EDGE_W'(aad_pkg::TARGET_EDGE)) &&
                 (h_eff <= aad_pkg::EDGE_W'(aad_pkg::TARGET_EDGE));
  assign area_full = w_eff * h_eff;

  assign gew    = remw_q >= dsh_q;
  assign geh    = remh_q >= dsh_q;
  assign remw_d = gew ? remw_q - dsh_q : remw_q;
  assign remh_d = geh ? remh_q - dsh_q : remh_q;
  assign qw_d   = {qw_q[aad_pkg::QUO_W-2:0], gew};
  assign qh_d   = {qh_q[aad_pkg::QUO_W-2:0], geh};

  assign cfg_hit = cfg_we_i && (cfg_index_i == aad_pkg::CFG_SRC_WIDTH ||
                                cfg_index_i == aad_pkg::CFG_SRC_HEIGHT);
  assign in_stall_o = sz_load_q || (sz_cnt_q != '0) || clr_busy_i || q_full_i;
  assign accept = in_valid_i && !in_stall_o;

  assign cend     = {1'b0, crem_q} + {3'b0, dw_q};
  assign rend     = {1'b0, rrem_q} + {3'b0, dh_q};
  assign two_col  = cend > w_eff;
  assign two_row  = rend > h_eff;
  assign col_done = cend >= w_eff;
  assign row_done = rend >= h_eff;
  assign wx0_f    = two_col ? w_eff - {1'b0, crem_q} : {3'b0, dw_q};
  assign wx1_f    = cend - w_eff;
  assign wy0_f    = two_row ? h_eff - {1'b0, rrem_q} : {3'b0, dh_q};
  assign wy1_f    = rend - h_eff;
  assign sx_inc   = {1'b0, sx_q} + aad_pkg::EDGE_W'(1);
  assign sy_inc   = {1'b0, sy_q} + aad_pkg::EDGE_W'(1);

  always_comb begin
    op_o.px      = in_data_i;
    op_o.xs0     = xs_q;
    op_o.ys0     = ys_q;
    op_o.two_col = two_col;
    op_o.two_row = two_row;
    op_o.wx0     = wx0_f[aad_pkg::WGT_W-1:0];
    op_o.wx1     = wx1_f[aad_pkg::WGT_W-1:0];
    op_o.wy0     = wy0_f[aad_pkg::WGT_W-1:0];
    op_o.wy1     = wy1_f[aad_pkg::WGT_W-1:0];
    op_o.emit    = col_done && row_done;
    op_o.last    = ({1'b0, xs_q} + aad_pkg::DST_W'(1) == dw_q) &&
                   ({1'b0, ys_q} + aad_pkg::DST_W'(1) == dh_q);
  end

  assign push_o        = accept;
  assign ctl_o.restart = cfg_hit;
  assign ctl_o.area    = area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_w_q   <= aad_pkg::CFG_W'(aad_pkg::TARGET_EDGE);
      reg_h_q   <= aad_pkg::CFG_W'(aad_pkg::TARGET_EDGE);
      sz_load_q <= 1'b0;
      sz_cnt_q  <= '0;
      remw_q    <= '0;
      remh_q    <= '0;
      dsh_q     <= '0;
      qw_q      <= '0;
      qh_q      <= '0;
      dw_q      <= aad_pkg::DST_W'(aad_pkg::TARGET_EDGE);
      dh_q      <= aad_pkg::DST_W'(aad_pkg::TARGET_EDGE);
      area_q    <= aad_pkg::AREA_W'(aad_pkg::TARGET_EDGE * aad_pkg::TARGET_EDGE);
      sx_q      <= '0;
      sy_q      <= '0;
      crem_q    <= '0;
      rrem_q    <= '0;
      xs_q      <= '0;
      ys_q      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == aad_pkg::CFG_SRC_WIDTH) reg_w_q <= cfg_data_i;
      else reg_h_q <= cfg_data_i;
      sz_load_q <= 1'b1;
      sz_cnt_q  <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      crem_q    <= '0;
      rrem_q    <= '0;
      xs_q      <= '0;
      ys_q      <= '0;
    end else if (sz_load_q) begin
      sz_load_q <= 1'b0;
      remw_q    <= {w_eff, 9'd0} + {9'd0, m_eff};
      remh_q    <= {h_eff, 9'd0} + {9'd0, m_eff};
      dsh_q     <= {m_eff, 9'd0};
      qw_q      <= '0;
      qh_q      <= '0;
      sz_cnt_q  <= 4'(aad_pkg::QUO_STEPS);
      area_q    <= area_full[aad_pkg::AREA_W-1:0];
    end else if (sz_cnt_q != '0) begin
      remw_q   <= remw_d;
      remh_q   <= remh_d;
      qw_q     <= qw_d;
      qh_q     <= qh_d;
      dsh_q    <= dsh_q >> 1;
      sz_cnt_q <= sz_cnt_q - 4'd1;
      if (sz_cnt_q == 4'd1) begin
        if (ident) begin
          dw_q <= w_eff[aad_pkg::DST_W-1:0];
          dh_q <= h_eff[aad_pkg::DST_W-1:0];
        end else begin
          dw_q <= (qw_d == '0) ? aad_pkg::DST_W'(1) : qw_d;
          dh_q <= (qh_d == '0) ? aad_pkg::DST_W'(1) : qh_d;
        end
      end
    end else if (accept) begin
      if (sx_inc >= w_eff) begin
        sx_q   <= '0;
        crem_q <= '0;
        xs_q   <= '0;
        if (sy_inc >= h_eff) begin
          sy_q   <= '0;
          rrem_q <= '0;
          ys_q   <= '0;
        end else begin
          sy_q <= sy_inc[aad_pkg::POS_W-1:0];
          if (row_done) begin
            rrem_q <= wy1_f[aad_pkg::POS_W-1:0];
            ys_q   <= ys_q + aad_pkg::COORD_W'(1);
          end else begin
            rrem_q <= rend[aad_pkg::POS_W-1:0];
          end
        end
      end else begin
        sx_q <= sx_inc[aad_pkg::POS_W-1:0];
        if (col_done) begin
          crem_q <= wx1_f[aad_pkg::POS_W-1:0];
          xs_q   <= xs_q + aad_pkg::COORD_W'(1);
        end else begin
          crem_q <= cend[aad_pkg::POS_W-1:0];
        end
      end
    end
  end

endmodule

/* design/aad_queue.sv */
`timescale 1ns / 1ps
module aad_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         flush_i,
  input  logic         push_i,
  input  aad_pkg::op_t data_i,
  input  logic         pop_i,
  output aad_pkg::op_t data_o,
  output logic         full_o,
  output logic         empty_o
);

  aad_pkg::op_t                  slot_q [aad_pkg::QUEUE_DEPTH];
  logic [aad_pkg::QUEUE_AW-1:0]  wp_q, rp_q;
  logic [aad_pkg::QUEUE_AW:0]    cnt_q;

  assign data_o  = slot_q[rp_q];
  assign full_o  = cnt_q == (aad_pkg::QUEUE_AW+1)'(aad_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slot_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + aad_pkg::QUEUE_AW'(1);
      if (pop_i && !empty_o) rp_q <= rp_q + aad_pkg::QUEUE_AW'(1);
      if ((push_i && !full_o) && !(pop_i && !empty_o)) cnt_q <= cnt_q + 1'b1;
      else if (!(push_i && !full_o) && (pop_i && !empty_o)) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* design/aad_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aad_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aad_pkg::ctl_t    ctl_i,
  input  logic             q_empty_i,
  input  aad_pkg::op_t     q_data_i,
  output logic             pop_o,
  output logic             clr_busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aad_pkg::out_pix_t out_data_o
);

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_WR   = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_PUT  = 3'd5;

  typedef logic [aad_pkg::NCH-1:0][aad_pkg::ACC_W-1:0] acc_word_t;

  acc_word_t                       acc_mem [aad_pkg::ACC_DEPTH];
  acc_word_t                       rd_q, sum, wdata;
  logic [2:0]                      state_q;
  logic [aad_pkg::ACC_AW-1:0]      clr_cnt_q, addr, waddr;
  logic                            we, j_q, i_q, emit_op;
  aad_pkg::op_t                    item_q;
  logic [aad_pkg::PROD_W-1:0]      wgt_q;
  logic [2*aad_pkg::WGT_W-1:0]     wgt_full;
  logic [aad_pkg::NCH-1:0][aad_pkg::PIX_W-1:0] px;
  logic [aad_pkg::PIX_W+aad_pkg::PROD_W-1:0]   prod [aad_pkg::NCH];
  logic [aad_pkg::NUM_W-1:0]       rem_q [aad_pkg::NCH];
  logic [aad_pkg::NUM_W-1:0]       rem_d [aad_pkg::NCH];
  logic [aad_pkg::QUO_W-1:0]       quo_q [aad_pkg::NCH];
  logic [aad_pkg::QUO_W-1:0]       quo_d [aad_pkg::NCH];
  logic [aad_pkg::PIX_W-1:0]       chan [aad_pkg::NCH];
  logic [aad_pkg::NUM_W-1:0]       dsh_q;
  logic [3:0]                      div_cnt_q;
  logic                            out_valid_q;
  aad_pkg::out_pix_t               out_q;

  assign px = {item_q.px.alpha_in, item_q.px.blue_in, item_q.px.green_in, item_q.px.red_in};
  assign addr = {item_q.ys0[0] ^ j_q, item_q.xs0 + aad_pkg::COORD_W'(i_q)};
  assign wgt_full = (j_q ? item_q.wy1 : item_q.wy0) * (i_q ? item_q.wx1 : item_q.wx0);
  assign emit_op = !j_q && !i_q && item_q.emit;

  always_comb begin
    for (int c = 0; c < aad_pkg::NCH; c++) begin
      prod[c]  = px[c] * wgt_q;
      sum[c]   = rd_q[c] + aad_pkg::ACC_W'(prod[c]);
      rem_d[c] = (rem_q[c] >= dsh_q) ? rem_q[c] - dsh_q : rem_q[c];
      quo_d[c] = {quo_q[c][aad_pkg::QUO_W-2:0], rem_q[c] >= dsh_q};
      chan[c]  = quo_q[c][aad_pkg::QUO_W-1] ? '1 : quo_q[c][aad_pkg::PIX_W-1:0];
    end
  end

  assign we    = (state_q == B_CLR) || (state_q == B_WR);
  assign waddr = (state_q == B_CLR) ? clr_cnt_q : addr;
  assign wdata = ((state_q == B_CLR) || emit_op) ? '0 : sum;

  assign pop_o       = (state_q == B_IDLE) && !q_empty_i && !ctl_i.restart;
  assign clr_busy_o  = state_q == B_CLR;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (we) acc_mem[waddr] <= wdata;
    if (state_q == B_RD) rd_q <= acc_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= q_data_i;
    if (state_q == B_RD) wgt_q <= wgt_full[aad_pkg::PROD_W-1:0];
    if (state_q == B_WR && emit_op) begin
      for (int c = 0; c < aad_pkg::NCH; c++) begin
        rem_q[c] <= {1'b0, sum[c], 1'b0} + aad_pkg::NUM_W'(ctl_i.area);
        quo_q[c] <= '0;
      end
      dsh_q <= {ctl_i.area, 9'd0};
    end else if (state_q == B_DIV) begin
      for (int c = 0; c < aad_pkg::NCH; c++) begin
        rem_q[c] <= rem_d[c];
        quo_q[c] <= quo_d[c];
      end
      dsh_q <= dsh_q >> 1;
    end
    if (state_q == B_PUT && !out_valid_q) begin
      out_q.red_out    <= chan[0];
      out_q.green_out  <= chan[1];
      out_q.blue_out   <= chan[2];
      out_q.alpha_out  <= chan[3];
      out_q.out_col    <= item_q.xs0;
      out_q.out_row    <= item_q.ys0;
      out_q.frame_last <= item_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_cnt_q   <= '0;
      j_q         <= 1'b0;
      i_q         <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (ctl_i.restart) begin
        state_q   <= B_CLR;
        clr_cnt_q <= '0;
      end else begin
        case (state_q)
          B_CLR: begin
            clr_cnt_q <= clr_cnt_q + aad_pkg::ACC_AW'(1);
            if (clr_cnt_q == aad_pkg::ACC_AW'(aad_pkg::ACC_DEPTH - 1)) state_q <= B_IDLE;
          end
          B_IDLE: begin
            if (pop_o) begin
              j_q     <= q_data_i.two_row;
              i_q     <= q_data_i.two_col;
              state_q <= B_RD;
            end
          end
          B_RD: state_q <= B_WR;
          B_WR: begin
            if (i_q) begin
              i_q     <= 1'b0;
              state_q <= B_RD;
            end else if (j_q) begin
              j_q     <= 1'b0;
              i_q     <= item_q.two_col;
              state_q <= B_RD;
            end else if (item_q.emit) begin
              div_cnt_q <= 4'(aad_pkg::QUO_STEPS - 1);
              state_q   <= B_DIV;
            end else begin
              state_q <= B_IDLE;
            end
          end
          B_DIV: begin
            div_cnt_q <= div_cnt_q - 4'd1;
            if (div_cnt_q == '0) state_q <= B_PUT;
          end
          B_PUT: begin
            if (!out_valid_q) begin
              out_valid_q <= 1'b1;
              state_q     <= B_IDLE;
            end
          end
          default: state_q <= B_CLR;
        endcase
      end
    end
  end

  `AAD_ASSERT(a_no_pop_in_clear, (state_q == B_CLR) |-> !pop_o, "queue popped during clear")
  `AAD_ASSERT(a_div_to_put, (state_q == B_DIV && div_cnt_q == '0 && !ctl_i.restart) |=> (state_q == B_PUT), "divider did not finish into output")
  `AAD_ASSERT(a_out_from_put, $rose(out_valid_q) |-> ($past(state_q) == B_PUT), "result raised outside output step")

endmodule
